// ===== src/tsm_pkg.sv =====
`default_nettype none
package tsm_pkg;

  // default sizes of the stored sample fields
  localparam int unsigned POS_BITS_DEF   = 24;
  localparam int unsigned TIME_BITS_DEF  = 32;
  localparam int unsigned COUNT_BITS_DEF = 32;

  // fixed widths of configuration registers and of some result fields
  localparam int unsigned JUMP_W = 24;
  localparam int unsigned GLIM_W = 32;
  localparam int unsigned DIST_W = 25;
  localparam int unsigned GAP_W  = 33;
  localparam int unsigned PREV_W = 32;

  localparam logic [JUMP_W-1:0] JUMP_LIMIT_RST = 24'd1000;
  localparam logic [GLIM_W-1:0] GAP_LIMIT_RST  = 32'd1000000;

  // register indexes
  localparam logic REG_JUMP_LIMIT = 1'b0;
  localparam logic REG_GAP_LIMIT  = 1'b1;

  localparam int unsigned QDEPTH = 2;

  typedef enum logic [1:0] {
    KIND_NORMAL    = 2'd0,
    KIND_REPEATED  = 2'd1,
    KIND_BACKWARD  = 2'd2,
    KIND_OVERSIZED = 2'd3
  } time_kind_e;

  typedef struct packed {
    logic       pair_valid;
    time_kind_e kind;
  } cls_t;

  typedef struct packed {
    logic [JUMP_W-1:0] jump_limit;
    logic [GLIM_W-1:0] gap_limit;
  } cfg_t;

endpackage
`default_nettype wire

// ===== src/tsm_queue.sv =====
`default_nettype none
module tsm_queue import tsm_pkg::*; #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = QDEPTH
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] data_i,
  input  wire logic         pop_i,
  output logic [W-1:0]      data_o,
  output logic              full_o,
  output logic              empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

// ===== src/tsm_front.sv =====
`default_nettype none
module tsm_front import tsm_pkg::*; #(
  parameter int unsigned POS_BITS  = POS_BITS_DEF,
  parameter int unsigned TIME_BITS = TIME_BITS_DEF,
  localparam int unsigned ENT_W    = 3 + 2 * POS_BITS + 2 * TIME_BITS + 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cfg_t                 cfg_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [TIME_BITS-1:0] time_us_i,
  input  wire logic [POS_BITS-1:0]  pos_x_i,
  input  wire logic [POS_BITS-1:0]  pos_y_i,
  input  wire logic                 start_of_track_i,
  input  wire logic                 full_i,
  output logic                      push_o,
  output logic [ENT_W-1:0]          entry_o
);

  localparam int unsigned CMPT_W = (TIME_BITS > GLIM_W) ? TIME_BITS : GLIM_W;

  logic [TIME_BITS-1:0] last_time_q;
  logic [POS_BITS-1:0]  last_x_q, last_y_q;
  logic                 have_last_q;

  logic                 accept;
  logic [POS_BITS:0]    dx_s, dy_s, dx_abs, dy_abs;
  logic [TIME_BITS:0]   gap_full;
  logic                 over;
  cls_t                 cls;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept;

  assign dx_s   = {pos_x_i[POS_BITS-1], pos_x_i} - {last_x_q[POS_BITS-1], last_x_q};
  assign dy_s   = {pos_y_i[POS_BITS-1], pos_y_i} - {last_y_q[POS_BITS-1], last_y_q};
  assign dx_abs = dx_s[POS_BITS] ? (~dx_s + 1'b1) : dx_s;
  assign dy_abs = dy_s[POS_BITS] ? (~dy_s + 1'b1) : dy_s;

  // top bit is the borrow: set when the timestamp went backwards
  assign gap_full = {1'b0, time_us_i} - {1'b0, last_time_q};
  assign over     = CMPT_W'(gap_full[TIME_BITS-1:0]) > CMPT_W'(cfg_i.gap_limit);

  always_comb begin
    cls.pair_valid = !start_of_track_i && have_last_q;
    if (time_us_i == last_time_q) begin
      cls.kind = KIND_REPEATED;
    end else if (gap_full[TIME_BITS]) begin
      cls.kind = KIND_BACKWARD;
    end else if (over) begin
      cls.kind = KIND_OVERSIZED;
    end else begin
      cls.kind = KIND_NORMAL;
    end
    if (cls.pair_valid) begin
      entry_o = {cls, dx_abs[POS_BITS-1:0], dy_abs[POS_BITS-1:0], gap_full, last_time_q};
    end else begin
      entry_o = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_last_q <= 1'b0;
      last_time_q <= '0;
      last_x_q    <= '0;
      last_y_q    <= '0;
    end else if (accept) begin
      have_last_q <= 1'b1;
      last_time_q <= time_us_i;
      last_x_q    <= pos_x_i;
      last_y_q    <= pos_y_i;
    end
  end

endmodule
`default_nettype wire

// ===== src/tsm_back.sv =====
`default_nettype none
module tsm_back import tsm_pkg::*; #(
  parameter int unsigned POS_BITS   = POS_BITS_DEF,
  parameter int unsigned TIME_BITS  = TIME_BITS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF,
  localparam int unsigned ENT_W     = 3 + 2 * POS_BITS + 2 * TIME_BITS + 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cfg_t              cfg_i,
  input  wire logic [ENT_W-1:0]  entry_i,
  input  wire logic              empty_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   pair_valid_o,
  output logic                   jump_flag_o,
  output logic [DIST_W-1:0]      step_distance_o,
  output logic [1:0]             time_kind_o,
  output logic signed [GAP_W-1:0] stamp_delta_o,
  output logic [PREV_W-1:0]      prev_time_o,
  output logic [COUNT_BITS-1:0]  total_count_o,
  output logic [COUNT_BITS-1:0]  jump_count_o,
  output logic [COUNT_BITS-1:0]  repeated_count_o,
  output logic [COUNT_BITS-1:0]  backward_count_o,
  output logic [COUNT_BITS-1:0]  oversized_count_o
);

  localparam int unsigned OPW    = (POS_BITS > JUMP_W) ? POS_BITS : JUMP_W;
  localparam int unsigned PROD_W = 2 * OPW;
  localparam int unsigned SUM_W  = 2 * POS_BITS + 1;
  localparam int unsigned CMP_W  = (SUM_W > 2 * JUMP_W) ? SUM_W : 2 * JUMP_W;
  localparam int unsigned ROOT_W = POS_BITS + 1;
  localparam int unsigned RAD_W  = 2 * ROOT_W;
  localparam int unsigned REM_W  = ROOT_W + 3;
  localparam int unsigned IT_W   = $clog2(ROOT_W);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_MX   = 3'd1;
  localparam logic [2:0] B_MY   = 3'd2;
  localparam logic [2:0] B_ML   = 3'd3;
  localparam logic [2:0] B_CMP  = 3'd4;
  localparam logic [2:0] B_ROOT = 3'd5;
  localparam logic [2:0] B_DONE = 3'd6;

  logic [2:0]           state_q, state_d;
  cls_t                 cls_q;
  logic [POS_BITS-1:0]  dx_q, dy_q;
  logic [TIME_BITS:0]   gap_q;
  logic [TIME_BITS-1:0] prev_q;
  logic [OPW-1:0]       mul_a;
  logic [PROD_W-1:0]    prod_q;
  logic [SUM_W-1:0]     sum_q;
  logic                 jump_q;
  logic [RAD_W-1:0]     rad_q;
  logic [REM_W-1:0]     rem_q, rem_sh, trial;
  logic [ROOT_W-1:0]    root_q;
  logic [IT_W-1:0]      it_q;
  logic                 load_out;
  logic                 out_valid_q;
  logic [1:0]           tot_inc;
  logic [COUNT_BITS+1:0] tot_sum;

  logic [COUNT_BITS-1:0] total_q, jump_cnt_q, rep_q, back_q, over_q;

  assign pop_o    = (state_q == B_IDLE) && !empty_i;
  assign load_out = (state_q == B_DONE) && (!out_valid_q || out_ready_i);

  // one shared multiplier for both squares and the squared limit
  always_comb begin
    unique case (state_q)
      B_MX:    mul_a = OPW'(dx_q);
      B_MY:    mul_a = OPW'(dy_q);
      default: mul_a = OPW'(cfg_i.jump_limit);
    endcase
  end

  assign rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: if (!empty_i) state_d = B_MX;
      B_MX:   state_d = B_MY;
      B_MY:   state_d = B_ML;
      B_ML:   state_d = B_CMP;
      B_CMP:  state_d = B_ROOT;
      B_ROOT: if (it_q == IT_W'(ROOT_W - 1)) state_d = B_DONE;
      B_DONE: if (load_out) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          {cls_q, dx_q, dy_q, gap_q, prev_q} <= entry_i;
        end
      end
      B_MX: prod_q <= mul_a * mul_a;
      B_MY: begin
        sum_q  <= SUM_W'(prod_q);
        prod_q <= mul_a * mul_a;
      end
      B_ML: begin
        sum_q  <= sum_q + SUM_W'(prod_q[2*POS_BITS-1:0]);
        prod_q <= mul_a * mul_a;
      end
      B_CMP: begin
        jump_q <= CMP_W'(sum_q) > CMP_W'(prod_q);
        rad_q  <= RAD_W'(sum_q);
        rem_q  <= '0;
        root_q <= '0;
        it_q   <= '0;
      end
      B_ROOT: begin
        rad_q <= rad_q << 2;
        it_q  <= it_q + 1'b1;
        if (rem_sh >= trial) begin
          rem_q  <= rem_sh - trial;
          root_q <= {root_q[ROOT_W-2:0], 1'b1};
        end else begin
          rem_q  <= rem_sh;
          root_q <= {root_q[ROOT_W-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  // output register and anomaly counters
  assign tot_inc = {1'b0, jump_q} + {1'b0, cls_q.kind != KIND_NORMAL};
  assign tot_sum = {2'b00, total_q} + (COUNT_BITS + 2)'(tot_inc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      total_q     <= '0;
      jump_cnt_q  <= '0;
      rep_q       <= '0;
      back_q      <= '0;
      over_q      <= '0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
        total_q <= (tot_sum > {2'b00, CNT_MAX}) ? CNT_MAX : tot_sum[COUNT_BITS-1:0];
        if (jump_q && jump_cnt_q != CNT_MAX) jump_cnt_q <= jump_cnt_q + 1'b1;
        if (cls_q.kind == KIND_REPEATED && rep_q != CNT_MAX) rep_q <= rep_q + 1'b1;
        if (cls_q.kind == KIND_BACKWARD && back_q != CNT_MAX) back_q <= back_q + 1'b1;
        if (cls_q.kind == KIND_OVERSIZED && over_q != CNT_MAX) over_q <= over_q + 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      pair_valid_o    <= cls_q.pair_valid;
      jump_flag_o     <= jump_q;
      step_distance_o <= DIST_W'(root_q);
      time_kind_o     <= cls_q.kind;
      stamp_delta_o   <= $signed(GAP_W'(gap_q));
      prev_time_o     <= PREV_W'(prev_q);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign total_count_o     = total_q;
  assign jump_count_o      = jump_cnt_q;
  assign repeated_count_o  = rep_q;
  assign backward_count_o  = back_q;
  assign oversized_count_o = over_q;

endmodule
`default_nettype wire

// ===== src/trajectory_sample_monitor_top.sv =====
`default_nettype none
// channel   direction  handshake                  payload
// ------------------------------------------------------------------------------
// in        input      in_valid_i / in_ready_o    time_us, pos_x, pos_y, start_of_track
// out       output     out_valid_o / out_ready_i  pair_valid .. oversized_count
// cfg       input      apb psel/penable/pwrite    paddr, pwdata, prdata (pready high)
//
// a result passes the queue, then the back's square, jump test and one-bit-a-cycle
// square root states, and is then held in the output register
// the back takes a new item only after it has gone back to idle from the last one
// the front classifies and queues up to two items while the back is busy
// reset clears the held sample, the queue, the counters and the output valid
// a stalled output holds the back in its last state; the queue absorbs input
module trajectory_sample_monitor_top import tsm_pkg::*; #(
  parameter int unsigned POS_BITS   = POS_BITS_DEF,
  parameter int unsigned TIME_BITS  = TIME_BITS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // apb configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [2:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  // sample input
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [TIME_BITS-1:0]  time_us_i,
  input  wire logic [POS_BITS-1:0]   pos_x_i,
  input  wire logic [POS_BITS-1:0]   pos_y_i,
  input  wire logic                  start_of_track_i,
  // result output
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic                       pair_valid_o,
  output logic                       jump_flag_o,
  output logic [DIST_W-1:0]          step_distance_o,
  output logic [1:0]                 time_kind_o,
  output logic signed [GAP_W-1:0]    stamp_delta_o,
  output logic [PREV_W-1:0]          prev_time_o,
  output logic [COUNT_BITS-1:0]      total_count_o,
  output logic [COUNT_BITS-1:0]      jump_count_o,
  output logic [COUNT_BITS-1:0]      repeated_count_o,
  output logic [COUNT_BITS-1:0]      backward_count_o,
  output logic [COUNT_BITS-1:0]      oversized_count_o
);

  localparam int unsigned ENT_W = 3 + 2 * POS_BITS + 2 * TIME_BITS + 1;

  cfg_t              cfg_q;
  logic              cfg_wr;
  logic              push, pop, full, empty;
  logic [ENT_W-1:0]  entry_in, entry_out;

  // register file: register index sits in address bit 2
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.jump_limit <= JUMP_LIMIT_RST;
      cfg_q.gap_limit  <= GAP_LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_JUMP_LIMIT: cfg_q.jump_limit <= pwdata[JUMP_W-1:0];
        REG_GAP_LIMIT:  cfg_q.gap_limit  <= pwdata[GLIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_JUMP_LIMIT: prdata = 32'(cfg_q.jump_limit);
      REG_GAP_LIMIT:  prdata = cfg_q.gap_limit;
      default:        prdata = '0;
    endcase
  end

  // front: differences, time classification, held previous sample
  tsm_front #(
    .POS_BITS  (POS_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .time_us_i        (time_us_i),
    .pos_x_i          (pos_x_i),
    .pos_y_i          (pos_y_i),
    .start_of_track_i (start_of_track_i),
    .full_i           (full),
    .push_o           (push),
    .entry_o          (entry_in)
  );

  // short queue between front and back
  tsm_queue #(
    .W     (ENT_W),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (entry_in),
    .pop_i   (pop),
    .data_o  (entry_out),
    .full_o  (full),
    .empty_o (empty)
  );

  // back: squares, jump test, square root, counters, output register
  tsm_back #(
    .POS_BITS   (POS_BITS),
    .TIME_BITS  (TIME_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .entry_i           (entry_out),
    .empty_i           (empty),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .pair_valid_o      (pair_valid_o),
    .jump_flag_o       (jump_flag_o),
    .step_distance_o   (step_distance_o),
    .time_kind_o       (time_kind_o),
    .stamp_delta_o     (stamp_delta_o),
    .prev_time_o       (prev_time_o),
    .total_count_o     (total_count_o),
    .jump_count_o      (jump_count_o),
    .repeated_count_o  (repeated_count_o),
    .backward_count_o  (backward_count_o),
    .oversized_count_o (oversized_count_o)
  );

  // counters stay put while a result waits for its transfer
  a_cnt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(total_count_o) && $stable(jump_count_o))
    else $error("counters moved under a pending result");

  // a sample with no partner carries no anomaly
  a_no_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !pair_valid_o |-> !jump_flag_o && time_kind_o == KIND_NORMAL
      && step_distance_o == '0)
    else $error("anomaly reported without a previous sample");

  // the total never falls behind the jump or the oversized counter
  a_total_ge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_count_o >= jump_count_o && total_count_o >= oversized_count_o)
    else $error("total counter below a component counter");

  // the queue never overflows: input stalls exactly while it is full
  a_q_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !in_ready_o && !push)
    else $error("push into a full queue");

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
module testbench import tsm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // widths of the block as instantiated (package defaults)
  localparam int unsigned POS_W    = POS_BITS_DEF;
  localparam int unsigned TIME_W   = TIME_BITS_DEF;
  localparam int unsigned COUNT_W  = COUNT_BITS_DEF;
  // queue register, back states and the bit-serial root loop, with some slack
  localparam int unsigned LATENCY  = POS_W + 12;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned RANDOM_PER_PHASE = 482;

  // one pose sample as it crosses the input channel
  typedef struct {
    logic [TIME_W-1:0]       time_us;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic                    start_of_track;
  } pose_sample_t;

  // one comparison report as it crosses the output channel
  typedef struct {
    logic                    pair_valid;
    logic                    jump_flag;
    logic [DIST_W-1:0]       step_distance;
    time_kind_e              kind;
    logic signed [GAP_W-1:0] stamp_delta;
    logic [PREV_W-1:0]       prev_time;
    logic [COUNT_W-1:0]      total_count;
    logic [COUNT_W-1:0]      jump_count;
    logic [COUNT_W-1:0]      repeated_count;
    logic [COUNT_W-1:0]      backward_count;
    logic [COUNT_W-1:0]      oversized_count;
  } pose_report_t;

  // clock, reset and every block input start at a known value
  logic                    clk_i            = 1'b0;
  logic                    rst_ni           = 1'b0;
  logic                    psel             = 1'b0;
  logic                    penable          = 1'b0;
  logic                    pwrite           = 1'b0;
  logic [2:0]              paddr            = '0;
  logic [31:0]             pwdata           = '0;
  logic [31:0]             prdata;
  logic                    pready;
  logic                    in_valid_i       = 1'b0;
  logic                    in_ready_o;
  logic [TIME_W-1:0]       time_us_i        = '0;
  logic [POS_W-1:0]        pos_x_i          = '0;
  logic [POS_W-1:0]        pos_y_i          = '0;
  logic                    start_of_track_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_ready_i      = 1'b0;
  logic                    pair_valid_o;
  logic                    jump_flag_o;
  logic [DIST_W-1:0]       step_distance_o;
  logic [1:0]              time_kind_o;
  logic signed [GAP_W-1:0] stamp_delta_o;
  logic [PREV_W-1:0]       prev_time_o;
  logic [COUNT_W-1:0]      total_count_o;
  logic [COUNT_W-1:0]      jump_count_o;
  logic [COUNT_W-1:0]      repeated_count_o;
  logic [COUNT_W-1:0]      backward_count_o;
  logic [COUNT_W-1:0]      oversized_count_o;

  // predictor copy of the configuration registers, at their reset values
  logic [JUMP_W-1:0]       jump_limit_mm = JUMP_LIMIT_RST;
  logic [GLIM_W-1:0]       gap_limit_us  = GAP_LIMIT_RST;

  // predictor copy of the held sample and the anomaly tallies
  logic [TIME_W-1:0]       held_time     = '0;
  logic signed [POS_W-1:0] held_x        = '0;
  logic signed [POS_W-1:0] held_y        = '0;
  logic                    sample_held   = 1'b0;
  logic [COUNT_W-1:0]      total_tally     = '0;
  logic [COUNT_W-1:0]      jump_tally      = '0;
  logic [COUNT_W-1:0]      repeat_tally    = '0;
  logic [COUNT_W-1:0]      backward_tally  = '0;
  logic [COUNT_W-1:0]      oversize_tally  = '0;

  // reports predicted for accepted samples, oldest first
  pose_report_t predicted_reports[$];

  int unsigned mismatch_count  = 0;
  int unsigned run_cycles      = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned ready_stall_pct = 0;

  trajectory_sample_monitor_top u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .time_us_i         (time_us_i),
    .pos_x_i           (pos_x_i),
    .pos_y_i           (pos_y_i),
    .start_of_track_i  (start_of_track_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .pair_valid_o      (pair_valid_o),
    .jump_flag_o       (jump_flag_o),
    .step_distance_o   (step_distance_o),
    .time_kind_o       (time_kind_o),
    .stamp_delta_o     (stamp_delta_o),
    .prev_time_o       (prev_time_o),
    .total_count_o     (total_count_o),
    .jump_count_o      (jump_count_o),
    .repeated_count_o  (repeated_count_o),
    .backward_count_o  (backward_count_o),
    .oversized_count_o (oversized_count_o)
  );

  always #5 clk_i = ~clk_i;

  // watchdog: a hung handshake ends the run here
  always @(posedge clk_i) begin
    run_cycles++;
    if (run_cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports outstanding",
               run_cycles, predicted_reports.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side back-pressure, drawn afresh every cycle
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= ready_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // floor of the square root, built one result bit at a time from the top
  function automatic logic [DIST_W-1:0] floor_root(input longint sum_sq);
    logic [DIST_W-1:0] root;
    logic [DIST_W-1:0] trial;
    longint            trial_wide;
    root = '0;
    for (int b = DIST_W - 1; b >= 0; b--) begin
      trial      = root;
      trial[b]   = 1'b1;
      trial_wide = longint'(trial);
      if (trial_wide * trial_wide <= sum_sq) root = trial;
    end
    return root;
  endfunction

  // tallies stick at all ones
  function automatic logic [COUNT_W-1:0] tally_up(input logic [COUNT_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  // works out the report for one accepted sample and moves the held state on
  task automatic predict_pose_report(input pose_sample_t s, output pose_report_t r);
    longint dx;
    longint dy;
    longint sum_sq;
    longint limit_sq;
    r.pair_valid    = 1'b0;
    r.jump_flag     = 1'b0;
    r.step_distance = '0;
    r.kind          = KIND_NORMAL;
    r.stamp_delta   = '0;
    r.prev_time     = '0;
    // a track start, or nothing held yet, means no comparison at all
    if (!s.start_of_track && sample_held) begin
      dx = longint'(s.pos_x) - longint'(held_x);
      dy = longint'(s.pos_y) - longint'(held_y);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      sum_sq   = dx * dx + dy * dy;
      limit_sq = longint'(jump_limit_mm) * longint'(jump_limit_mm);
      r.pair_valid    = 1'b1;
      r.prev_time     = held_time;
      r.step_distance = floor_root(sum_sq);
      // squared values compared exactly, so the floored root is not used here
      if (sum_sq > limit_sq) begin
        r.jump_flag = 1'b1;
        jump_tally  = tally_up(jump_tally);
        total_tally = tally_up(total_tally);
      end
      r.stamp_delta = {1'b0, s.time_us} - {1'b0, held_time};
      // repeated wins over backward, backward over oversized
      if (s.time_us == held_time) begin
        r.kind       = KIND_REPEATED;
        repeat_tally = tally_up(repeat_tally);
        total_tally  = tally_up(total_tally);
      end else if (s.time_us < held_time) begin
        r.kind         = KIND_BACKWARD;
        backward_tally = tally_up(backward_tally);
        total_tally    = tally_up(total_tally);
      end else if (s.time_us - held_time > gap_limit_us) begin
        r.kind         = KIND_OVERSIZED;
        oversize_tally = tally_up(oversize_tally);
        total_tally    = tally_up(total_tally);
      end
    end
    held_time   = s.time_us;
    held_x      = s.pos_x;
    held_y      = s.pos_y;
    sample_held = 1'b1;
    r.total_count     = total_tally;
    r.jump_count      = jump_tally;
    r.repeated_count  = repeat_tally;
    r.backward_count  = backward_tally;
    r.oversized_count = oversize_tally;
  endtask

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  // one line per mismatch
  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
  endtask

  // every result transfer is held against the oldest prediction
  always @(posedge clk_i) begin : check_reports
    pose_report_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (predicted_reports.size() == 0) begin
        report_mismatch("result transfer with no report outstanding");
      end else begin
        want = predicted_reports.pop_front();
        check_field("pair_valid",      64'(pair_valid_o),      64'(want.pair_valid));
        check_field("jump_flag",       64'(jump_flag_o),       64'(want.jump_flag));
        check_field("step_distance",   64'(step_distance_o),   64'(want.step_distance));
        check_field("time_kind",       64'(time_kind_o),       64'(want.kind));
        check_field("stamp_delta",     64'(stamp_delta_o),     64'(want.stamp_delta));
        check_field("prev_time",       64'(prev_time_o),       64'(want.prev_time));
        check_field("total_count",     64'(total_count_o),     64'(want.total_count));
        check_field("jump_count",      64'(jump_count_o),      64'(want.jump_count));
        check_field("repeated_count",  64'(repeated_count_o),  64'(want.repeated_count));
        check_field("backward_count",  64'(backward_count_o),  64'(want.backward_count));
        check_field("oversized_count", 64'(oversized_count_o), 64'(want.oversized_count));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic pose_sample_t pose(input logic [TIME_W-1:0] t,
                                        input logic signed [POS_W-1:0] x,
                                        input logic signed [POS_W-1:0] y,
                                        input logic start);
    pose_sample_t s;
    s.time_us        = t;
    s.pos_x          = x;
    s.pos_y          = y;
    s.start_of_track = start;
    return s;
  endfunction

  // presents one sample, optionally after a random idle stretch, and waits for
  // its transfer; valid is left high so a following sample can go back to back
  task automatic send_sample(input pose_sample_t s);
    pose_report_t r;
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < sender_idle_pct);
    end
    in_valid_i       <= 1'b1;
    time_us_i        <= s.time_us;
    pos_x_i          <= s.pos_x;
    pos_y_i          <= s.pos_y;
    start_of_track_i <= s.start_of_track;
    do @(posedge clk_i); while (!in_ready_o);
    predict_pose_report(s, r);
    predicted_reports.insert(predicted_reports.size(), r);
  endtask

  // stops sending until every predicted report has come back, then lets the
  // pipeline settle
  task automatic wait_for_reports_drained();
    in_valid_i <= 1'b0;
    while (predicted_reports.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  // apb write: setup cycle, then access cycle until pready, then the bus goes idle
  task automatic write_register(input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    // bits above each register's width are dropped
    case (idx)
      REG_JUMP_LIMIT: jump_limit_mm = value[JUMP_W-1:0];
      REG_GAP_LIMIT:  gap_limit_us  = value[GLIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_limits(input logic [31:0] jump_word, input logic [31:0] gap_word);
    wait_for_reports_drained();
    write_register(REG_JUMP_LIMIT, jump_word);
    write_register(REG_GAP_LIMIT, gap_word);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // corner samples at the reset limits (1000 mm, 1 s)
  task automatic test_directed_cases();
    sender_idle_pct = 0;
    ready_stall_pct = 0;
    // first sample without a start flag: nothing held yet, so no comparison
    send_sample(pose(32'd100, 24'sd0, 24'sd0, 1'b0));
    // repeated timestamp, distance exactly on the limit, no jump
    send_sample(pose(32'd100, 24'sd1000, 24'sd0, 1'b0));
    // backward timestamp, one millimetre over the limit
    send_sample(pose(32'd50, 24'sd2001, 24'sd0, 1'b0));
    // gap exactly at the limit is normal; 600/800 step sits right on the limit
    send_sample(pose(32'd1000050, 24'sd2601, 24'sd800, 1'b0));
    // one microsecond over the gap limit, no movement
    send_sample(pose(32'd2000051, 24'sd2601, 24'sd800, 1'b0));
    // new track at the top of the time range and the bottom corner of space
    send_sample(pose(32'hFFFF_FFFF, -24'sd8388608, -24'sd8388608, 1'b1));
    // widest backward gap and the longest possible diagonal
    send_sample(pose(32'd0, 24'sd8388607, 24'sd8388607, 1'b0));
    // widest forward gap, full span on one axis
    send_sample(pose(32'hFFFF_FFFF, -24'sd8388608, 24'sd8388607, 1'b0));
    // start flag mid-stream suppresses the comparison even on a repeated time
    send_sample(pose(32'hFFFF_FFFF, 24'sd8388607, -24'sd8388608, 1'b1));
    // alternating bit patterns on every field
    send_sample(pose(32'h5555_5555, 24'sh555555, 24'shAAAAAA, 1'b0));
    send_sample(pose(32'hAAAA_AAAA, 24'shAAAAAA, 24'sh555555, 1'b0));
    send_sample(pose(32'hAAAA_AAAB, -24'sd1, -24'sd1, 1'b0));
    send_sample(pose(32'hAAAA_AAAC, 24'sd0, 24'sd0, 1'b0));
  endtask

  // both limits at zero and at all ones; upper junk in the write data is ignored
  task automatic test_limit_extremes();
    sender_idle_pct = 35;
    ready_stall_pct = 35;
    set_limits(32'hFF00_0000, 32'h0000_0000);
    send_sample(pose(32'd10, 24'sd5, 24'sd5, 1'b1));
    // any forward step is oversized, a zero move is not a jump
    send_sample(pose(32'd11, 24'sd5, 24'sd5, 1'b0));
    // one millimetre is already a jump
    send_sample(pose(32'd11, 24'sd6, 24'sd5, 1'b0));
    send_sample(pose(32'd12, 24'sd6, 24'sd5, 1'b0));
    set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_sample(pose(32'd0, -24'sd8388608, -24'sd8388608, 1'b1));
    // widest gap equals the limit; the diagonal still beats the widest limit
    send_sample(pose(32'hFFFF_FFFF, 24'sd8388607, 24'sd8388607, 1'b0));
    // full span on one axis lands exactly on the limit
    send_sample(pose(32'hFFFF_FFFF, -24'sd8388608, 24'sd8388607, 1'b0));
  endtask

  // mostly well-formed tracks with steps spread around both limits,
  // with some unrelated noise samples thrown in
  task automatic test_random_tracks(input int unsigned idle_pct, input int unsigned stall_pct,
                                    input logic [31:0] jump_word, input logic [31:0] gap_word);
    pose_sample_t s;
    int           track_left;
    int unsigned  roll;
    int unsigned  span;
    int unsigned  reach;
    int           delta;
    set_limits(jump_word, gap_word);
    sender_idle_pct = idle_pct;
    ready_stall_pct = stall_pct;
    track_left = 0;
    s = pose('0, '0, '0, 1'b1);
    span  = (gap_limit_us >= 32'd1_000_000) ? 2_000_000 : gap_limit_us * 2 + 2;
    reach = (jump_limit_mm > 24'd2000) ? 4000 : jump_limit_mm * 2 + 4;
    for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        // noise: every field random
        s = pose($urandom, POS_W'($urandom), POS_W'($urandom), 1'($urandom_range(0, 1)));
      end else if (track_left == 0) begin
        s = pose($urandom, POS_W'($urandom), POS_W'($urandom), 1'b1);
        track_left = $urandom_range(2, 24);
      end else begin
        track_left--;
        s.start_of_track = 1'b0;
        roll = $urandom_range(0, 99);
        if (roll < 60)      s.time_us = s.time_us + $urandom_range(1, span);
        else if (roll < 68) s.time_us = s.time_us + gap_limit_us;
        else if (roll < 76) s.time_us = s.time_us + gap_limit_us + 1;
        else if (roll < 84) s.time_us = s.time_us;
        else if (roll < 92) s.time_us = s.time_us - $urandom_range(1, span);
        else                s.time_us = $urandom;
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
          delta   = int'($urandom_range(0, 2 * reach)) - int'(reach);
          s.pos_x = s.pos_x + delta[POS_W-1:0];
          delta   = int'($urandom_range(0, 2 * reach)) - int'(reach);
          s.pos_y = s.pos_y + delta[POS_W-1:0];
        end else if (roll < 75) begin
          // one axis only, just under, on or just over the jump limit
          delta = int'(jump_limit_mm) + int'($urandom_range(0, 2)) - 1;
          if ($urandom_range(0, 1)) delta = -delta;
          if ($urandom_range(0, 1)) s.pos_x = s.pos_x + delta[POS_W-1:0];
          else                      s.pos_y = s.pos_y + delta[POS_W-1:0];
        end else if (roll < 85) begin
          // standing still
        end else begin
          s.pos_x = POS_W'($urandom);
          s.pos_y = POS_W'($urandom);
        end
      end
      send_sample(s);
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_limit_extremes();
    // four random phases, each with its own pair of limits; each one starts
    // only after every report of the last has come back
    test_random_tracks(0, 0, 32'(JUMP_LIMIT_RST), GAP_LIMIT_RST);
    test_random_tracks(64, 0, $urandom_range(1, 4000), $urandom_range(1000, 3_000_000));
    test_random_tracks(0, 64, $urandom, $urandom);
    test_random_tracks(35, 35, 32'd3, 32'd10);

    wait_for_reports_drained();
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
